### rtl/eitsp_pkg.sv
// Package of types, constants and record codes for the EIT section parser.
`default_nettype none
package eitsp_pkg;
   localparam int NameLimitDef       = 64;
   localparam int TextLimitDef       = 255;
   localparam int VideoLimitDef      = 4;
   localparam int AudioLimitDef      = 4;
   localparam int VideoNameLimitDef  = 16;
   localparam int AudioNameLimitDef  = 32;

   localparam logic [3:0] KIND_HEADER    = 4'd0;
   localparam logic [3:0] KIND_UNCHANGED = 4'd1;
   localparam logic [3:0] KIND_EVENT     = 4'd2;
   localparam logic [3:0] KIND_NAME      = 4'd3;
   localparam logic [3:0] KIND_TEXT      = 4'd4;
   localparam logic [3:0] KIND_VIDEO     = 4'd5;
   localparam logic [3:0] KIND_AUDIO     = 4'd6;
   localparam logic [3:0] KIND_COMPNAME  = 4'd7;
   localparam logic [3:0] KIND_END       = 4'd8;
   localparam logic [3:0] KIND_REJECT    = 4'd9;

   localparam logic [15:0] REASON_TABLE  = 16'd1;
   localparam logic [15:0] REASON_FIELDS = 16'd2;
   localparam logic [15:0] REASON_STREAM = 16'd3;
   localparam logic [15:0] REASON_SHORT  = 16'd4;

   localparam logic [2:0] CSR_TABLE_ID  = 3'd0;
   localparam logic [2:0] CSR_STREAM_ID = 3'd1;
   localparam logic [2:0] CSR_SHORT_TAG = 3'd2;
   localparam logic [2:0] CSR_VIDEO_TAG = 3'd3;
   localparam logic [2:0] CSR_AUDIO_TAG = 3'd4;
   localparam logic [2:0] CSR_ML_MASK   = 3'd5;

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_SKIP   = 3'd1;
   localparam logic [2:0] PH_EVENT  = 3'd2;
   localparam logic [2:0] PH_DTAG   = 3'd3;
   localparam logic [2:0] PH_DLEN   = 3'd4;
   localparam logic [2:0] PH_BODY   = 3'd5;

   localparam logic [11:0] POS_MAX = 12'd4095;

   typedef struct packed {
      logic [7:0]  table_id;
      logic [15:0] stream_id;
      logic [7:0]  short_tag;
      logic [7:0]  video_tag;
      logic [7:0]  audio_tag;
      logic [7:0]  ml_mask;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [3:0]  record_kind;
      logic [15:0] word_a;
      logic [15:0] word_b;
      logic [15:0] word_c;
      logic [23:0] wide_a;
      logic [23:0] wide_b;
      logic [7:0]  small_a;
      logic [7:0]  small_b;
      logic [7:0]  small_c;
      logic [7:0]  small_d;
      logic [7:0]  text_index;
   } rsp_type;

   // Word passed from the front part to the record queue.
   typedef struct packed {
      logic    emit;
      rsp_type rec;
   } job_type;

   function automatic logic [7:0] cap8(input logic [12:0] v, input logic [7:0] lim);
      cap8 = (v > {5'd0, lim}) ? lim : v[7:0];
   endfunction
endpackage
`default_nettype wire

### rtl/eitsp_stream_if.sv
// Valid/ready channel interface carrying one word of payload.
`default_nettype none
interface eitsp_stream_if #(parameter int Width = 8);
   logic             valid;
   logic             ready;
   logic [Width-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/eit_section_parser_core.sv
// EIT section parser: top level joining front part, record queue and output stage.
//
// Usage: section bytes enter on the req channel, one word per byte with
// last set on the final byte. Records leave on the rsp channel, at
// most one per input word. Registers must be written on the csr port only
// while the block is idle; the block itself does not enforce this.
// Each record passes through the queue and then the output register before
// it appears on rsp. Throughput: one byte per cycle while the queue is not
// full; the front part parses each byte combinationally as it is accepted.
// When the receiver stalls, records collect in the two-entry queue and the
// output register; req ready drops once the queue is full, so nothing is
// lost. Reset is synchronous and clears parse state, stored versions and
// the registers to their defaults; the block is ready in the cycle after.
`default_nettype none
module eit_section_parser_core
   import eitsp_pkg::*;
#(
   parameter int NameLimit      = NameLimitDef,
   parameter int TextLimit      = TextLimitDef,
   parameter int VideoLimit     = VideoLimitDef,
   parameter int AudioLimit     = AudioLimitDef,
   parameter int VideoNameLimit = VideoNameLimitDef,
   parameter int AudioNameLimit = AudioNameLimitDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   eitsp_stream_if.sink     req,
   eitsp_stream_if.source   rsp,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   cfg_type cfg_ff, cfg_in;
   job_type job;
   req_type item;
   rsp_type head;
   logic    full, not_empty, take, step;

   assign item  = req_type'(req.payload[8:0]);
   assign req.ready = !full;
   assign step  = req.valid && req.ready;

   // Register file writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_TABLE_ID:  cfg_in.table_id  = csr_data[7:0];
            CSR_STREAM_ID: cfg_in.stream_id = csr_data;
            CSR_SHORT_TAG: cfg_in.short_tag = csr_data[7:0];
            CSR_VIDEO_TAG: cfg_in.video_tag = csr_data[7:0];
            CSR_AUDIO_TAG: cfg_in.audio_tag = csr_data[7:0];
            CSR_ML_MASK:   cfg_in.ml_mask   = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{table_id: 8'd78, stream_id: 16'd0, short_tag: 8'd77,
                     video_tag: 8'd80, audio_tag: 8'd196, ml_mask: 8'd128};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   eitsp_front #(
      .NameLimit(NameLimit), .TextLimit(TextLimit), .VideoLimit(VideoLimit),
      .AudioLimit(AudioLimit), .VideoNameLimit(VideoNameLimit),
      .AudioNameLimit(AudioNameLimit)
   ) u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .step(step), .item(item), .job(job)
   );

   eitsp_queue u_queue (
      .clock(clock), .reset(reset), .push(step && job.emit), .push_rec(job.rec),
      .full(full), .pop(take), .not_empty(not_empty), .head(head)
   );

   rsp_type out_rec;
   eitsp_back u_back (
      .clock(clock), .reset(reset), .have(not_empty), .rec(head), .take(take),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_rec(out_rec)
   );
   assign rsp.payload = out_rec;

`ifndef ASSERT_OFF
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !req.ready) else $error("byte accepted with queue full");
   a_take_needs_data: assert property (@(posedge clock) disable iff (reset)
      take |-> not_empty) else $error("output loaded from empty queue");
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.payload[139:136] <= KIND_REJECT))
      else $error("record kind out of range");
`endif
endmodule
`default_nettype wire

### rtl/eitsp_front.sv
// Front part: accepts section bytes, tracks parse state and builds records.
`default_nettype none
module eitsp_front
   import eitsp_pkg::*;
#(
   parameter int NameLimit      = NameLimitDef,
   parameter int TextLimit      = TextLimitDef,
   parameter int VideoLimit     = VideoLimitDef,
   parameter int AudioLimit     = AudioLimitDef,
   parameter int VideoNameLimit = VideoNameLimitDef,
   parameter int AudioNameLimit = AudioNameLimitDef
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    step,
   input  wire req_type item,
   output job_type      job
);
   localparam int CntW = $clog2(16 + 1);
   localparam logic [7:0] NameLim  = 8'(NameLimit);
   localparam logic [7:0] TextLim  = 8'(TextLimit);
   localparam logic [7:0] VNameLim = 8'(VideoNameLimit);
   localparam logic [7:0] ANameLim = 8'(AudioNameLimit);
   localparam logic [CntW-1:0] VLim = CntW'(VideoLimit);
   localparam logic [CntW-1:0] ALim = CntW'(AudioLimit);
   localparam logic [CntW-1:0] CntOne = CntW'(1);

   logic [11:0] pos_ff, pos_in, slen_ff, slen_in, drem_ff, drem_in;
   logic [7:0]  hdr_ff [14];
   logic [7:0]  hdr_in [14];
   logic [4:0]  sver_ff [2];
   logic [4:0]  sver_in [2];
   logic [1:0]  vval_ff, vval_in;
   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  efi_ff, efi_in;
   logic [7:0]  dtag_ff, dtag_in, dleft_ff, dleft_in, doff_ff, doff_in, slen8_ff, slen8_in;
   logic [63:0] acc0_ff, acc0_in, acc1_ff, acc1_in;
   logic [CntW-1:0] vcnt_ff, vcnt_in, acnt_ff, acnt_in;
   logic        rej_ff, rej_in;

   // Parse step for one byte; mirrors the section grammar.
   always_comb begin
      logic [7:0]  b, raw, flags, b10, h5, h6;
      logic [11:0] dend;
      logic [12:0] total, sum3;
      logic [3:0]  ep, idx;
      logic        multi, sel, data_ok;
      logic [63:0] a0, a1;
      logic [4:0]  ver;
      b = item.data;
      pos_in = pos_ff; slen_in = slen_ff; drem_in = drem_ff;
      hdr_in = hdr_ff; sver_in = sver_ff; vval_in = vval_ff;
      phase_in = phase_ff; efi_in = efi_ff; dtag_in = dtag_ff;
      dleft_in = dleft_ff; doff_in = doff_ff; slen8_in = slen8_ff;
      acc0_in = acc0_ff; acc1_in = acc1_ff; vcnt_in = vcnt_ff;
      acnt_in = acnt_ff; rej_in = rej_ff;
      job = '0;
      h5 = (pos_ff == 12'd5) ? b : hdr_ff[5];
      h6 = (pos_ff == 12'd6) ? b : hdr_ff[6];
      ver = h5[5:1];
      sel = (h6 != 8'd0);
      sum3 = {1'b0, slen_ff} + 13'd3;
      dend = (sum3 > 13'd4) ? 12'(sum3 - 13'd4) : 12'd0;
      total = {5'd0, doff_ff} + {5'd0, dleft_ff};
      raw = acc0_ff[7:0];
      flags = acc1_ff[7:0];
      multi = (doff_ff >= 8'd6) && ((flags & cfg.ml_mask) != 8'd0);
      ep = multi ? 4'd11 : 4'd8;
      a0 = '0; a1 = '0; idx = '0; b10 = '0; data_ok = 1'b0;
      if (phase_ff == PH_HEADER) begin
         if (pos_ff < 12'd14) hdr_in[pos_ff[3:0]] = b;
         if (pos_ff == 12'd2) slen_in = {hdr_ff[1][3:0], b};
         if (pos_ff >= 12'd13) begin
            job.emit = 1'b1;
            if (hdr_ff[0] != cfg.table_id) begin
               job.rec.record_kind = KIND_REJECT; job.rec.word_a = REASON_TABLE;
               rej_in = 1'b1; phase_in = PH_SKIP;
            end else if (!hdr_ff[5][0] || hdr_ff[7] != 8'd1 || hdr_ff[12] != 8'd1 ||
                         ((pos_ff == 12'd13) ? b : hdr_ff[13]) != hdr_ff[0]) begin
               job.rec.record_kind = KIND_REJECT; job.rec.word_a = REASON_FIELDS;
               rej_in = 1'b1; phase_in = PH_SKIP;
            end else if ({hdr_ff[8], hdr_ff[9]} != cfg.stream_id) begin
               job.rec.record_kind = KIND_REJECT; job.rec.word_a = REASON_STREAM;
               rej_in = 1'b1; phase_in = PH_SKIP;
            end else if (vval_ff[sel] && sver_ff[sel] == ver) begin
               job.rec.record_kind = KIND_UNCHANGED;
               job.rec.word_a = {hdr_ff[3], hdr_ff[4]};
               job.rec.small_a = {3'd0, ver}; job.rec.small_b = {7'd0, sel};
               rej_in = 1'b1; phase_in = PH_SKIP;
            end else if (item.last) begin
               job.rec.record_kind = KIND_REJECT; job.rec.word_a = REASON_SHORT;
               rej_in = 1'b1; phase_in = PH_SKIP;
            end else begin
               sver_in[sel] = ver; vval_in[sel] = 1'b1;
               vcnt_in = '0; acnt_in = '0; efi_in = '0;
               phase_in = PH_EVENT; rej_in = 1'b0;
               job.rec.record_kind = KIND_HEADER;
               job.rec.word_a = {hdr_ff[3], hdr_ff[4]};
               job.rec.word_b = {hdr_ff[8], hdr_ff[9]};
               job.rec.word_c = {hdr_ff[10], hdr_ff[11]};
               job.rec.small_a = {3'd0, ver}; job.rec.small_b = {7'd0, sel};
            end
         end else if (item.last) begin
            job.emit = 1'b1;
            job.rec.record_kind = KIND_REJECT; job.rec.word_a = REASON_SHORT;
            rej_in = 1'b1; phase_in = PH_SKIP;
         end
      end else if (item.last) begin
         if (!rej_ff) begin
            job.emit = 1'b1;
            job.rec.record_kind = KIND_END;
            job.rec.word_a = {hdr_ff[3], hdr_ff[4]};
            job.rec.small_a = {3'd0, hdr_ff[5][5:1]};
            job.rec.small_b = {7'd0, hdr_ff[6] != 8'd0};
         end
      end else if (phase_ff != PH_SKIP) begin
         if (pos_ff < dend) data_ok = 1'b1;
         else phase_in = PH_SKIP;
      end

      // Data bytes of an accepted section.
      if (data_ok) begin
         if (phase_ff == PH_EVENT) begin
            idx = efi_ff;
            if (idx < 4'd8) acc0_in = {acc0_ff[55:0], b};
            else acc1_in = {32'd0, acc1_ff[23:0], b};
            idx = idx + 4'd1;
            if (idx >= 4'd12) begin
               a0 = acc0_ff; a1 = {32'd0, acc1_ff[23:0], b};
               b10 = a1[15:8];
               job.emit = 1'b1;
               job.rec.record_kind = KIND_EVENT;
               job.rec.word_a = a0[63:48];
               job.rec.word_b = a0[47:32];
               job.rec.wide_a = a0[31:8];
               job.rec.wide_b = {a0[7:0], a1[31:16]};
               job.rec.small_c = {7'd0, b10[4]};
               drem_in = {b10[3:0], a1[7:0]};
               phase_in = (drem_in != 12'd0) ? PH_DTAG : PH_EVENT;
               idx = '0;
            end
            efi_in = idx;
         end else begin
            if (phase_ff == PH_DTAG) begin
               dtag_in = b; phase_in = PH_DLEN;
            end else if (phase_ff == PH_DLEN) begin
               dleft_in = b; doff_in = '0; slen8_in = '0;
               acc0_in = '0; acc1_in = '0;
               phase_in = (b != 8'd0) ? PH_BODY : PH_DTAG;
            end else begin
               if (dtag_ff == cfg.short_tag) begin
                  if (doff_ff == 8'd3) begin
                     acc0_in = {56'd0, b}; slen8_in = cap8({5'd0, b}, NameLim);
                  end else if (doff_ff > 8'd3) begin
                     if ({1'b0, doff_ff} < 9'd4 + {1'b0, raw}) begin
                        if (doff_ff - 8'd4 < slen8_ff) begin
                           job.emit = 1'b1; job.rec.record_kind = KIND_NAME;
                           job.rec.small_a = b; job.rec.text_index = doff_ff - 8'd4;
                        end
                     end else if ({1'b0, doff_ff} == 9'd4 + {1'b0, raw}) begin
                        slen8_in = cap8({5'd0, b}, TextLim);
                     end else if (doff_ff - 8'd5 - raw < slen8_ff) begin
                        job.emit = 1'b1; job.rec.record_kind = KIND_TEXT;
                        job.rec.small_a = b; job.rec.text_index = doff_ff - 8'd5 - raw;
                     end
                  end
               end else if (dtag_ff == cfg.video_tag) begin
                  if (doff_ff == 8'd1) acc1_in = {56'd0, b};
                  else if (doff_ff == 8'd2) begin
                     if (vcnt_ff < VLim) begin
                        vcnt_in = vcnt_ff + CntOne;
                        slen8_in = cap8((total > 13'd6) ? total - 13'd6 : 13'd0, VNameLim);
                        job.emit = 1'b1; job.rec.record_kind = KIND_VIDEO;
                        job.rec.small_a = acc1_ff[7:0]; job.rec.small_b = b;
                     end else slen8_in = '0;
                  end else if (doff_ff >= 8'd6 && doff_ff - 8'd6 < slen8_ff) begin
                     job.emit = 1'b1; job.rec.record_kind = KIND_COMPNAME;
                     job.rec.small_a = b; job.rec.text_index = doff_ff - 8'd6;
                  end
               end else if (dtag_ff == cfg.audio_tag) begin
                  a1 = acc1_ff;
                  if (doff_ff == 8'd1) a1[31:24] = a1[31:24] | b;
                  else if (doff_ff == 8'd2) a1[23:16] = a1[23:16] | b;
                  else if (doff_ff == 8'd3) a1[15:8] = a1[15:8] | b;
                  else if (doff_ff == 8'd5) a1[7:0] = a1[7:0] | b;
                  acc1_in = a1;
                  a0 = acc0_ff;
                  if (doff_ff >= 8'd6 && doff_ff <= {4'd0, ep}) begin
                     a0 = {16'd0, acc0_ff[39:0], b};
                     acc0_in = a0;
                  end
                  if (doff_ff == {4'd0, ep}) begin
                     if (acnt_ff < ALim) begin
                        acnt_in = acnt_ff + CntOne;
                        slen8_in = cap8(total - {9'd0, ep} - 13'd1, ANameLim);
                        job.emit = 1'b1; job.rec.record_kind = KIND_AUDIO;
                        job.rec.wide_a = multi ? a0[47:24] : a0[23:0];
                        job.rec.wide_b = multi ? a0[23:0] : 24'd0;
                        job.rec.small_a = a1[31:24]; job.rec.small_b = a1[23:16];
                        job.rec.small_c = a1[15:8]; job.rec.small_d = flags;
                     end else slen8_in = '0;
                  end else if (doff_ff > {4'd0, ep} &&
                               doff_ff - {4'd0, ep} - 8'd1 < slen8_ff) begin
                     job.emit = 1'b1; job.rec.record_kind = KIND_COMPNAME;
                     job.rec.small_a = b; job.rec.text_index = doff_ff - {4'd0, ep} - 8'd1;
                  end
               end
               doff_in = doff_ff + 8'd1;
               dleft_in = dleft_ff - 8'd1;
               if (dleft_in == 8'd0) phase_in = PH_DTAG;
            end
            drem_in = drem_ff - 12'd1;
            if (drem_in == 12'd0) begin
               phase_in = PH_EVENT; efi_in = '0;
            end
         end
      end

      if (item.last) begin
         pos_in = '0; phase_in = PH_HEADER; rej_in = 1'b0;
      end else if (pos_ff < POS_MAX) pos_in = pos_ff + 12'd1;
   end

   // Header shadow and accumulators hold payload only.
   always_ff @(posedge clock) begin
      if (step) begin
         hdr_ff <= hdr_in; acc0_ff <= acc0_in; acc1_ff <= acc1_in;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; slen_ff <= '0; drem_ff <= '0;
         sver_ff <= '{default: '0}; vval_ff <= '0; phase_ff <= PH_HEADER;
         efi_ff <= '0; dtag_ff <= '0; dleft_ff <= '0; doff_ff <= '0;
         slen8_ff <= '0; vcnt_ff <= '0; acnt_ff <= '0; rej_ff <= 1'b0;
      end else if (step) begin
         pos_ff <= pos_in; slen_ff <= slen_in; drem_ff <= drem_in;
         sver_ff <= sver_in; vval_ff <= vval_in; phase_ff <= phase_in;
         efi_ff <= efi_in; dtag_ff <= dtag_in; dleft_ff <= dleft_in;
         doff_ff <= doff_in; slen8_ff <= slen8_in; vcnt_ff <= vcnt_in;
         acnt_ff <= acnt_in; rej_ff <= rej_in;
      end
   end
endmodule
`default_nettype wire

### rtl/eitsp_queue.sv
// Two-entry record queue between the front and back parts.
`default_nettype none
module eitsp_queue
   import eitsp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_rec,
   output logic         full,
   input  wire logic    pop,
   output logic         not_empty,
   output rsp_type      head
);
   rsp_type     slot_ff [2];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = slot_ff[rp_ff];

   // Pointer and count update.
   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= push_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

### rtl/eitsp_back.sv
// Back part: output register that presents records to the receiver.
`default_nettype none
module eitsp_back
   import eitsp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    have,
   input  wire rsp_type rec,
   output logic         take,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_rec
);
   logic    vld_ff, vld_in;
   rsp_type rec_ff;

   // Load from the queue, when it holds a record, whenever the register is empty or being drained.
   assign take      = have && (!vld_ff || out_ready);
   assign vld_in    = take || (vld_ff && !out_ready);
   assign out_valid = vld_ff;
   assign out_rec   = rec_ff;

   always_ff @(posedge clock) begin
      if (take) rec_ff <= rec;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else vld_ff <= vld_in;
   end
endmodule
`default_nettype wire
